// ----- hdl/isfp_pkg.sv -----
// Shared types, constants and helpers for the serial frame parser.
package isfp_pkg;

   // Result event codes
   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_HEADER     = 3'd1,
      EV_PAYLOAD    = 3'd2,
      EV_RPC_GOOD   = 3'd3,
      EV_OTHER_GOOD = 3'd4,
      EV_SUM_BAD    = 3'd5,
      EV_REJECT     = 3'd6,
      EV_TIMEOUT    = 3'd7
   } event_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_VERSION = 2'd0,
      CSR_RPC     = 2'd1,
      CSR_TIMEOUT = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_index_type;

   localparam int POS_W    = 9;
   localparam int IDLE_W   = 16;
   localparam int CSR_W    = 16;

   localparam logic [POS_W-1:0] POS_VERSION = 9'd6;
   localparam logic [POS_W-1:0] POS_TYPE    = 9'd7;
   localparam logic [POS_W-1:0] POS_LENGTH  = 9'd8;
   localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd9;

   localparam logic [7:0]        VERSION_RST = 8'd1;
   localparam logic [7:0]        RPC_RST     = 8'd3;
   localparam logic [IDLE_W-1:0] TIMEOUT_RST = 16'd50;
   localparam logic [IDLE_W-1:0] IDLE_MAX    = 16'hFFFF;

   // One result transaction
   typedef struct packed {
      event_type  ev;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] frame_type;
      logic [7:0] frame_length;
   } rsp_type;

   // Expected ASCII header byte "IMPROV" at positions 0..5
   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h49; // I
         3'd1:    c = 8'h4D; // M
         3'd2:    c = 8'h50; // P
         3'd3:    c = 8'h52; // R
         3'd4:    c = 8'h4F; // O
         3'd5:    c = 8'h56; // V
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/improv_serial_frame_parser_core.sv -----
// Serial frame parser core: header check, payload stream, checksum and idle timeout.
//
// Each request transaction carries one received byte (tuser = 0) or one time
// tick (tuser = 1) and yields exactly one response transaction. An item is
// processed in the cycle it is accepted: the frame position, running checksum,
// held type/length and idle tick counter are updated in that same cycle and the
// result lands in the output register (or the skid register while that is held),
// so the block sustains one item per clock while req_tready is high. A two-entry
// output stage (output register plus skid register) lets a new request be taken
// while a finished result still waits on rsp_tready; req_tready drops only when
// both entries are full. Configuration writes take effect on the next item.
module improv_serial_frame_parser_core
   import isfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             req_tuser,   // [0] mode
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                         // [23:16] frame_type, [31:24] frame_length
   output logic [2:0]       rsp_tuser,   // [2:0] event_res
   // configuration port
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   // configuration registers
   logic [7:0]        version_ff;
   logic [7:0]        rpc_ff;
   logic [IDLE_W-1:0] timeout_ff;

   // parser state
   logic [POS_W-1:0]  pos_ff,   pos_in;
   logic [7:0]        type_ff,  type_in;
   logic [7:0]        len_ff,   len_in;
   logic [7:0]        sum_ff,   sum_in;
   logic [IDLE_W-1:0] idle_ff,  idle_in;

   // output stage
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff,       out_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_type           skid_ff,       skid_in;

   logic              accept;
   logic              take;
   rsp_type           res;

   logic              mode;
   logic [7:0]        b;
   logic [IDLE_W-1:0] idle_inc;
   logic [POS_W-1:0]  pay_end;
   logic [POS_W-1:0]  pay_off;
   logic              clear;

   assign mode    = req_tuser;
   assign b       = req_tdata;
   assign accept  = req_tvalid && req_tready;
   assign take    = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RST;
         rpc_ff     <= RPC_RST;
         timeout_ff <= TIMEOUT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_VERSION: version_ff <= csr_wdata[7:0];
            CSR_RPC:     rpc_ff     <= csr_wdata[7:0];
            CSR_TIMEOUT: timeout_ff <= csr_wdata;
            CSR_UNUSED:  ;
            default:     ;
         endcase
      end
   end

   assign idle_inc = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign pay_end  = POS_PAYLOAD + {1'b0, len_ff};
   assign pay_off  = pos_ff - POS_PAYLOAD;

   // per-item parse step
   always_comb begin
      pos_in  = pos_ff;
      type_in = type_ff;
      len_in  = len_ff;
      sum_in  = sum_ff;
      idle_in = idle_ff;
      clear   = 1'b0;
      res.ev            = EV_NONE;
      res.payload_byte  = 8'd0;
      res.payload_index = 8'd0;

      if (mode) begin
         idle_in = idle_inc;
         if (idle_inc > timeout_ff) begin
            idle_in = '0;
            if (pos_ff != '0) begin
               res.ev = EV_TIMEOUT;
               clear  = 1'b1;
            end
         end
      end else if (pos_ff < POS_VERSION) begin
         if (b == hdr_char(pos_ff[2:0])) begin
            res.ev = EV_HEADER;
         end else begin
            res.ev = EV_REJECT;
            clear  = 1'b1;
         end
      end else if (pos_ff == POS_VERSION) begin
         if (b == version_ff) begin
            res.ev = EV_HEADER;
         end else begin
            res.ev = EV_REJECT;
            clear  = 1'b1;
         end
      end else if (pos_ff == POS_TYPE) begin
         type_in = b;
         res.ev  = EV_HEADER;
      end else if (pos_ff == POS_LENGTH) begin
         len_in = b;
         res.ev = EV_HEADER;
      end else if (pos_ff < pay_end) begin
         res.ev            = EV_PAYLOAD;
         res.payload_byte  = b;
         res.payload_index = pay_off[7:0];
      end else begin
         // checksum byte closes the frame
         if (b != sum_ff)          res.ev = EV_SUM_BAD;
         else if (type_ff == rpc_ff) res.ev = EV_RPC_GOOD;
         else                      res.ev = EV_OTHER_GOOD;
         clear = 1'b1;
      end

      // frame fields shown before any clear
      res.frame_type   = type_in;
      res.frame_length = len_in;

      // accepted bytes restart the idle count and advance the frame
      if (!mode && res.ev != EV_REJECT && res.ev != EV_SUM_BAD) begin
         idle_in = '0;
         if (!clear) begin
            sum_in = sum_ff + b;
            pos_in = pos_ff + 9'd1;
         end
      end
      if (clear) begin
         pos_in  = '0;
         type_in = '0;
         len_in  = '0;
         sum_in  = '0;
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         type_ff <= '0;
         len_ff  <= '0;
         sum_ff  <= '0;
         idle_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         type_ff <= type_in;
         len_ff  <= len_in;
         sum_ff  <= sum_in;
         idle_ff <= idle_in;
      end
   end

   // output register plus skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.ev;
   assign rsp_tdata  = {out_ff.frame_length, out_ff.frame_type,
                        out_ff.payload_index, out_ff.payload_byte};

endmodule

// ----- sim/frame_checker.sv -----
// Scoreboard for the serial frame parser: watches all channels, predicts and compares responses.
`timescale 1ns / 1ps

module frame_checker
   import isfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             req_tuser,   // [0] mode
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [31:0]      rsp_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                         // [23:16] frame_type, [31:24] frame_length
   input  logic [2:0]       rsp_tuser,   // [2:0] event_res
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               fail_count,
   output int               outstanding,
   output logic [7:0]       seen_events
);

   // "IMPROV", first character in the top byte
   localparam logic [47:0] MAGIC       = "IMPROV";

   // Predicted parser state and register copies
   logic [POS_W-1:0]  at_byte;
   logic [7:0]        held_type;
   logic [7:0]        held_len;
   logic [7:0]        frame_sum;
   logic [IDLE_W-1:0] ticks_idle;
   logic [7:0]        cfg_version;
   logic [7:0]        cfg_rpc;
   logic [IDLE_W-1:0] cfg_timeout;

   rsp_type expected_reports[$];
   rsp_type want;
   int      n_fail = 0;

   // Advance the predicted parser by one byte or tick, return the report it makes
   function automatic rsp_type parse_step(input logic tick, input logic [7:0] b);
      rsp_type r;
      logic    drop;
      r    = '0;
      r.ev = EV_NONE;
      drop = 1'b0;
      if (tick) begin
         if (ticks_idle != IDLE_MAX) ticks_idle++;
         if (ticks_idle > cfg_timeout) begin
            ticks_idle = '0;
            if (at_byte != '0) begin
               r.ev = EV_TIMEOUT;
               drop = 1'b1;
            end
         end
      end else if (at_byte < POS_VERSION) begin
         if (b == MAGIC[47 - 8*int'(at_byte) -: 8]) r.ev = EV_HEADER;
         else begin
            r.ev = EV_REJECT;
            drop = 1'b1;
         end
      end else if (at_byte == POS_VERSION) begin
         if (b == cfg_version) r.ev = EV_HEADER;
         else begin
            r.ev = EV_REJECT;
            drop = 1'b1;
         end
      end else if (at_byte == POS_TYPE) begin
         held_type = b;
         r.ev      = EV_HEADER;
      end else if (at_byte == POS_LENGTH) begin
         held_len = b;
         r.ev     = EV_HEADER;
      end else if (int'(at_byte) < int'(POS_PAYLOAD) + int'(held_len)) begin
         r.ev            = EV_PAYLOAD;
         r.payload_byte  = b;
         r.payload_index = 8'(at_byte - POS_PAYLOAD);
      end else begin
         // checksum byte closes the frame
         if (b != frame_sum)            r.ev = EV_SUM_BAD;
         else if (held_type == cfg_rpc) r.ev = EV_RPC_GOOD;
         else                           r.ev = EV_OTHER_GOOD;
         drop = 1'b1;
      end

      r.frame_type   = held_type;
      r.frame_length = held_len;

      // accepted bytes restart the idle count and advance the frame
      if (!tick && r.ev != EV_REJECT && r.ev != EV_SUM_BAD) begin
         ticks_idle = '0;
         if (!drop) begin
            frame_sum = frame_sum + b;
            at_byte   = at_byte + 1'b1;
         end
      end
      if (drop) begin
         at_byte   = '0;
         held_type = '0;
         held_len  = '0;
         frame_sum = '0;
      end
      return r;
   endfunction

   task automatic check_field(input string what, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         n_fail++;
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         at_byte     = '0;
         held_type   = '0;
         held_len    = '0;
         frame_sum   = '0;
         ticks_idle  = '0;
         cfg_version = VERSION_RST;
         cfg_rpc     = RPC_RST;
         cfg_timeout = TIMEOUT_RST;
         expected_reports.delete();
         seen_events <= '0;
      end else begin
         // response transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen_events[rsp_tuser] <= 1'b1;
            if (expected_reports.size() == 0) begin
               n_fail++;
               $display("%0t unexpected response: expected none, actual event %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_reports.pop_front();
               check_field("event_res",     want.ev,            rsp_tuser);
               check_field("payload_byte",  want.payload_byte,  rsp_tdata[7:0]);
               check_field("payload_index", want.payload_index, rsp_tdata[15:8]);
               check_field("frame_type",    want.frame_type,    rsp_tdata[23:16]);
               check_field("frame_length",  want.frame_length,  rsp_tdata[31:24]);
            end
         end
         // request transaction
         if (req_tvalid && req_tready)
            expected_reports = {expected_reports, parse_step(req_tuser, req_tdata)};
         // register writes apply from the next item on
         if (csr_we) begin
            case (csr_addr)
               CSR_VERSION: cfg_version = csr_wdata[7:0];
               CSR_RPC:     cfg_rpc     = csr_wdata[7:0];
               CSR_TIMEOUT: cfg_timeout = csr_wdata;
               default:     ;
            endcase
         end
      end
      outstanding <= expected_reports.size();
      fail_count  <= n_fail;
   end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the serial frame parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import isfp_pkg::*;

   localparam logic [47:0] MAGIC = "IMPROV";

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = '0;
   logic             req_tuser  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b1;
   logic [31:0]      rsp_tdata;
   logic [2:0]       rsp_tuser;
   logic             csr_we     = 1'b0;
   logic [1:0]       csr_addr   = '0;
   logic [CSR_W-1:0] csr_wdata  = '0;

   int         fail_count;
   int         outstanding;
   logic [7:0] seen_events;

   // Stimulus knobs and register shadow
   int                sent          = 0;
   int                send_idle_pct = 0;
   int                stall_pct     = 0;
   int                tick_mix      = 0;
   logic [7:0]        cur_version   = VERSION_RST;
   logic [7:0]        cur_rpc       = RPC_RST;
   logic [IDLE_W-1:0] cur_timeout   = TIMEOUT_RST;

   improv_serial_frame_parser_core u_top (.*);

   frame_checker u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver backpressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Run limit
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // One request transaction, with optional sender gaps ahead of it
   task automatic send_item(input logic tick, input logic [7:0] b);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= tick;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Hold off the sender until every response is back, then let the block settle
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] ver, input logic [7:0] rpc,
                            input logic [IDLE_W-1:0] tmo, input bit poke_spare);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_VERSION;
      csr_wdata <= {8'($urandom), ver};
      @(posedge clock);
      csr_addr  <= CSR_RPC;
      csr_wdata <= {8'($urandom), rpc};
      @(posedge clock);
      csr_addr  <= CSR_TIMEOUT;
      csr_wdata <= tmo;
      @(posedge clock);
      if (poke_spare) begin
         csr_addr  <= CSR_UNUSED;
         csr_wdata <= 16'($urandom);
         @(posedge clock);
      end
      csr_we      <= 1'b0;
      cur_version  = ver;
      cur_rpc      = rpc;
      cur_timeout  = tmo;
   endtask

   // Full frame; break_at >= 0 corrupts that byte and abandons the frame there
   task automatic send_frame(input logic [7:0] ver, input logic [7:0] ftype, input int len,
                             input int break_at, input logic bad_sum);
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      sum = '0;
      for (i = 0; i < 10 + len; i++) begin
         if (i < 6)            b = MAGIC[47 - 8*i -: 8];
         else if (i == 6)      b = ver;
         else if (i == 7)      b = ftype;
         else if (i == 8)      b = len[7:0];
         else if (i < 9 + len) b = 8'($urandom);
         else                  b = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
         if (i == break_at) b = b ^ 8'($urandom_range(1, 255));
         send_item(1'b0, b);
         sum = sum + b;
         if (i == break_at) break;
         // stray ticks, now and then a burst long enough to time out
         if (tick_mix != 0 && $urandom_range(99) < tick_mix)
            send_item(1'b1, 8'($urandom));
         if (tick_mix != 0 && cur_timeout <= 40 && $urandom_range(99) < 3)
            repeat (int'(cur_timeout) + 1) send_item(1'b1, 8'($urandom));
      end
   endtask

   // Mostly well-formed frames, some bad sums, broken headers and noise
   task automatic random_traffic(input int n_items);
      int         goal;
      int         sel;
      int         len;
      logic [7:0] ftype;
      logic [7:0] ver;
      goal = sent + n_items;
      while (sent < goal) begin
         sel   = $urandom_range(99);
         len   = ($urandom_range(19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
         ftype = ($urandom_range(1) == 0) ? cur_rpc : 8'($urandom);
         ver   = ($urandom_range(9) == 0) ? 8'($urandom) : cur_version;
         if (sel < 70)      send_frame(ver, ftype, len, -1, 1'b0);
         else if (sel < 80) send_frame(ver, ftype, len, -1, 1'b1);
         else if (sel < 90) send_frame(ver, ftype, len, $urandom_range(0, 6), 1'b0);
         else
            repeat ($urandom_range(1, 4))
               send_item($urandom_range(3) == 0,
                         ($urandom_range(4) == 0) ? 8'h49 : 8'($urandom));
      end
   endtask

   task automatic set_profile(input int idle_pct, input int stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
   endtask

   initial begin
      int i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: good RPC frame with empty payload, junk at idle, tick at idle,
      // other-type frame with a bad sum, then a zero timeout mid-header
      send_frame(VERSION_RST, RPC_RST, 0, -1, 1'b0);
      send_item(1'b0, 8'h00);
      send_item(1'b1, 8'hFF);
      send_frame(VERSION_RST, 8'hFF, 1, -1, 1'b1);
      settle();
      configure(VERSION_RST, RPC_RST, 16'd0, 1'b0);
      send_item(1'b0, MAGIC[47:40]);
      send_item(1'b0, MAGIC[39:32]);
      send_item(1'b1, 8'h00);
      send_item(1'b1, 8'hFF);
      settle();

      // Random phases across idle profiles and register settings
      tick_mix = 8;
      set_profile(0, 0);
      configure(8'd1, 8'd3, 16'd3, 1'b0);
      random_traffic(30);
      settle();
      set_profile(71, 0);
      configure(8'h00, 8'hFF, 16'd1, 1'b0);
      random_traffic(30);
      settle();
      set_profile(0, 71);
      configure(8'hFF, 8'h00, 16'hFFFF, 1'b0);
      random_traffic(30);
      settle();
      set_profile(34, 34);
      configure(8'($urandom), 8'($urandom), 16'($urandom_range(2, 20)), 1'b1);
      random_traffic(30);
      settle();

      // Longest payload, then a partial header left to time out
      tick_mix = 0;
      set_profile(0, 0);
      configure(8'h80, 8'h7F, 16'hFFFF, 1'b0);
      send_frame(8'h80, 8'h7F, 255, -1, 1'b0);
      for (i = 0; i < 5; i++) send_item(1'b0, MAGIC[47 - 8*i -: 8]);
      settle();
      configure(8'h80, 8'h7F, 16'd3, 1'b1);
      repeat (4) send_item(1'b1, 8'($urandom));
      settle();
      repeat (8) @(posedge clock);

      $display("Summary: %0d request transactions: frames, header breaks, bad sums, noise",
               sent);
      $display("and ticks under four idle/stall profiles; events seen (bit per code) %b",
               seen_events);
      if (fail_count == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
